// ----- hdl/esc_pkg.sv -----
package esc_pkg;

  localparam int Levels      = 10;
  localparam int ThreshCount = 9;
  localparam int LvlUsed     = (Levels - 1 < ThreshCount) ? Levels - 1 : ThreshCount;
  localparam int LvlW        = $clog2(LvlUsed + 1);

  localparam int ActW    = 2;
  localparam int ResW    = 8;
  localparam int TimeW   = 32;
  localparam int CntW    = 32;
  localparam int SensW   = 7;
  localparam int TmoW    = 16;
  localparam int ReloadW = 14;

  localparam int ReloadShift = $clog2(256);
  localparam logic [ReloadW-1:0] ReloadPos = ReloadW'(255);

  localparam int DivSteps = CntW;
  localparam int MulSteps = SensW;
  localparam int StepW    = $clog2(DivSteps);
  localparam int MulIdxW  = $clog2(MulSteps);

  localparam int AddrW = 3;
  localparam int DataW = 32;

  typedef logic [ResW-1:0] thresh_t;
  localparam thresh_t Thresholds [ThreshCount] = '{
    8'd210, 8'd214, 8'd222, 8'd230, 8'd234, 8'd238, 8'd242, 8'd246, 8'd250
  };

  localparam logic [ActW-1:0] ActReport = 2'd0;
  localparam logic [ActW-1:0] ActTick   = 2'd1;
  localparam logic [ActW-1:0] ActScale  = 2'd2;

  localparam logic RegBase    = 1'b0;
  localparam logic RegTimeout = 1'b1;

  localparam logic [TmoW-1:0] TimeoutRst = 16'd5000;

  typedef struct packed {
    logic             start;
    logic             mul;
    logic [SensW-1:0] mag;
    logic [CntW-1:0]  opnd;
  } alu_req_t;

  typedef struct packed {
    logic            done;
    logic [CntW-1:0] result;
  } alu_rsp_t;

  function automatic logic [ReloadW-1:0] reload_of(logic [SensW-1:0] s);
    logic [SensW-1:0]  m;
    logic [ReloadW:0]  w;
    m = -s;
    w = ({{(ReloadW + 1 - SensW){1'b0}}, m} << ReloadShift) - (ReloadW + 1)'(1);
    return s[SensW-1] ? w[ReloadW-1:0] : ReloadPos;
  endfunction

endpackage

// ----- hdl/esc_derive.sv -----
module esc_derive (
  input  logic [esc_pkg::ResW-1:0]  resistance_i,
  input  logic [esc_pkg::SensW-1:0] base_i,
  output logic [esc_pkg::SensW-1:0] sens_o
);
  import esc_pkg::*;

  localparam int ExtW = SensW + 1;

  logic [LvlW-1:0] n;
  logic            run;
  logic [ExtW-1:0] b_ext;
  logic [ExtW-1:0] n_ext;
  logic [ExtW-1:0] t;
  logic [ExtW-1:0] s;

  always_comb begin
    n   = '0;
    run = 1'b1;
    for (int i = 0; i < LvlUsed; i++) begin
      if (run && resistance_i >= Thresholds[i]) begin
        n = n + LvlW'(1);
      end else begin
        run = 1'b0;
      end
    end
  end

  assign b_ext = {base_i[SensW-1], base_i};
  assign n_ext = {{(ExtW - LvlW){1'b0}}, n};
  assign t     = b_ext - n_ext;

  always_comb begin
    priority if (n == '0) begin
      s = b_ext;
    end else if (base_i == '0) begin
      s = ~n_ext;
    end else if (base_i[SensW-1]) begin
      s = t;
    end else if (t[ExtW-1] || t == '0) begin
      s = t - ExtW'(2);
    end else begin
      s = t;
    end
  end

  assign sens_o = (s[ExtW-1] && !s[ExtW-2]) ? {1'b1, {(SensW - 1){1'b0}}} : s[SensW-1:0];

endmodule

// ----- hdl/esc_alu.sv -----
module esc_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  esc_pkg::alu_req_t req_i,
  output esc_pkg::alu_rsp_t rsp_o
);
  import esc_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               mul_q;
  logic [StepW-1:0]   cnt_q;
  logic [SensW-1:0]   mag_q;
  logic [SensW-2:0]   rem_q;
  logic [CntW-1:0]    w_q;
  logic [CntW-1:0]    opnd_q;

  logic [CntW:0]      op_a;
  logic [CntW:0]      op_b;
  logic [CntW:0]      sum;
  logic               sub;
  logic [SensW-1:0]   rem_sh;
  logic               qbit;

  assign rem_sh = {rem_q, w_q[CntW-1]};

  always_comb begin
    if (mul_q) begin
      sub  = 1'b0;
      op_a = {1'b0, w_q[CntW-2:0], 1'b0};
      op_b = mag_q[cnt_q[MulIdxW-1:0]] ? {1'b0, opnd_q} : '0;
    end else begin
      sub  = 1'b1;
      op_a = {{(CntW + 1 - SensW){1'b0}}, rem_sh};
      op_b = {{(CntW + 1 - SensW){1'b0}}, mag_q};
    end
  end

  assign sum  = op_a + (sub ? ~op_b : op_b) + {{CntW{1'b0}}, sub};
  assign qbit = !sum[CntW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
    end else if (busy_q && cnt_q == '0) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mul_q  <= req_i.mul;
      mag_q  <= req_i.mag;
      opnd_q <= req_i.opnd;
      rem_q  <= '0;
      w_q    <= req_i.mul ? '0 : req_i.opnd;
      cnt_q  <= req_i.mul ? StepW'(MulSteps - 1) : StepW'(DivSteps - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - StepW'(1);
      if (mul_q) begin
        w_q <= sum[CntW-1:0];
      end else begin
        w_q   <= {w_q[CntW-2:0], qbit};
        rem_q <= qbit ? sum[SensW-2:0] : rem_sh[SensW-2:0];
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = w_q;

endmodule

// ----- hdl/encoder_sensitivity_scaler.sv -----
// Channel    Dir  Handshake          Payload
// s_axis     in   tvalid/tready      tuser: action; tdata: resistance, now_ms, raw_count
// m_axis     out  tvalid/tready      tdata: sensitivity, reload_value, scaled_count
// apb        in   psel/penable       base_sensitivity at 0x0, timeout_ms at 0x4
//
// Reports, ticks and unused actions finish in the cycle they are accepted.
// A count item is divided when the sensitivity is negative (32 steps of the
// shared add/subtract unit plus start and finish), multiplied when it is
// positive (7 steps), and passed through when the sensitivity is zero.
// Reset clears the sensitivity state and the base and loads a 5000 ms timeout.
// A waiting result holds off the input; the next item enters as it is taken.
module encoder_sensitivity_scaler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [1:0] action
  input  logic [1:0]                 s_axis_tuser_i,
  // [7:0] resistance, [39:8] now_ms, [71:40] raw_count
  input  logic [71:0]                s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [6:0] sensitivity, [20:7] reload_value, [52:21] scaled_count, [55:53] zero
  output logic [55:0]                m_axis_tdata_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [esc_pkg::AddrW-1:0]  paddr,
  input  logic [esc_pkg::DataW-1:0]  pwdata,
  output logic [esc_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import esc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                state_q, state_d;
  logic [SensW-1:0]    base_q;
  logic [TmoW-1:0]     tmo_q;
  logic [SensW-1:0]    cur_q, cur_d;
  logic [ResW-1:0]     last_res_q;
  logic [TimeW-1:0]    last_time_q;
  logic                out_valid_q, out_valid_d;
  logic [SensW-1:0]    out_sens_q;
  logic [ReloadW-1:0]  out_reload_q;
  logic [CntW-1:0]     out_scaled_q;

  logic [ActW-1:0]     action;
  logic [ResW-1:0]     resistance;
  logic [TimeW-1:0]    now_ms;
  logic [CntW-1:0]     raw_count;

  logic                accept;
  logic                cfg_wr;
  logic                need_alu;
  logic                load_now;
  logic [SensW-1:0]    derived;
  logic [TimeW-1:0]    elapsed;
  logic [CntW-1:0]     scaled_now;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  assign action     = s_axis_tuser_i;
  assign resistance = s_axis_tdata_i[7:0];
  assign now_ms     = s_axis_tdata_i[39:8];
  assign raw_count  = s_axis_tdata_i[71:40];

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_wr          = psel && penable && pwrite && pready;
  assign elapsed         = now_ms - last_time_q;

  esc_derive u_derive (
    .resistance_i (resistance),
    .base_i       (base_q),
    .sens_o       (derived)
  );

  esc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign need_alu      = (action == ActScale) && (cur_q != '0);
  assign load_now      = accept && !need_alu;
  assign alu_req.start = accept && need_alu;
  assign alu_req.mul   = !cur_q[SensW-1];
  assign alu_req.mag   = cur_q[SensW-1] ? -cur_q : cur_q;
  assign alu_req.opnd  = raw_count;
  assign scaled_now    = (action == ActScale) ? raw_count : '0;

  always_comb begin
    cur_d = cur_q;
    if (accept) begin
      unique case (action)
        ActReport: begin
          if (resistance != last_res_q) begin
            cur_d = derived;
          end
        end
        ActTick: begin
          if (cur_q != base_q && elapsed > {{(TimeW - TmoW){1'b0}}, tmo_q}) begin
            cur_d = base_q;
          end
        end
        default: begin
          cur_d = cur_q;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    if (alu_req.start) begin
      state_d = ST_RUN;
    end else if (alu_rsp.done) begin
      state_d = ST_IDLE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_now || alu_rsp.done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      tmo_q       <= TimeoutRst;
      cur_q       <= '0;
      last_res_q  <= '0;
      last_time_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr && paddr[AddrW-1:2] == RegBase) begin
        base_q <= pwdata[SensW-1:0];
        cur_q  <= pwdata[SensW-1:0];
      end else begin
        cur_q <= cur_d;
      end
      if (cfg_wr && paddr[AddrW-1:2] == RegTimeout) begin
        tmo_q <= pwdata[TmoW-1:0];
      end
      if (accept && action == ActReport) begin
        last_time_q <= now_ms;
        last_res_q  <= resistance;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_now) begin
      out_sens_q   <= cur_d;
      out_reload_q <= reload_of(cur_d);
      out_scaled_q <= scaled_now;
    end else if (alu_rsp.done) begin
      out_sens_q   <= cur_q;
      out_reload_q <= reload_of(cur_q);
      out_scaled_q <= alu_rsp.result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_scaled_q, out_reload_q, out_sens_q};

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[AddrW-1:2])
      RegBase:    prdata = {{(DataW - SensW){1'b0}}, base_q};
      RegTimeout: prdata = {{(DataW - TmoW){1'b0}}, tmo_q};
      default:    prdata = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_done_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == ST_RUN)
    else $error("divider result outside a count item");

  a_run_no_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> !out_valid_q)
    else $error("result pending while the shared unit is busy");

  a_reload_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_sens_q[SensW-1]) |-> out_reload_q == ReloadPos)
    else $error("reload value inconsistent with non-negative sensitivity");

  a_run_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && alu_rsp.done) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("count item not delivered on completion");
`endif

endmodule
